// ===== rtl/lpcr_pkg.sv =====
// Types and constants shared by the length-prefixed chunk reader modules.
`timescale 1ns / 1ps
`default_nettype none

package lpcr_pkg;

  localparam int unsigned BufferDepth = 4096;
  localparam int unsigned MaxDigits   = 12;

  // Declared length is kept saturated one above the largest max_length value.
  localparam int unsigned LenW   = 14;
  localparam logic [LenW-1:0] LenSat    = 14'd8192;
  localparam logic [LenW-1:0] LenBuffer = LenW'(BufferDepth);
  localparam logic [3:0]      DigitsMax = 4'(MaxDigits);

  localparam logic [7:0] CharCr   = 8'h0D;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;

  localparam logic [15:0] ResetRetryInterval = 16'd1000;
  localparam logic [15:0] ResetRespTimeout   = 16'd5000;
  localparam logic [3:0]  ResetRetryLimit    = 4'd3;
  localparam logic [12:0] ResetMaxLength     = 13'd4096;
  localparam logic [31:0] ResetChunkOffset   = 32'd0;
  localparam logic        ResetLinkReady     = 1'b1;

  typedef enum logic [2:0] {
    RegRetryInterval = 3'd0,
    RegRespTimeout   = 3'd1,
    RegRetryLimit    = 3'd2,
    RegMaxLength     = 3'd3,
    RegChunkOffset   = 3'd4,
    RegLinkReady     = 3'd5
  } lpcr_reg_e;

  typedef enum logic [1:0] {
    ActTick  = 2'd0,
    ActError = 2'd1,
    ActByte  = 2'd2
  } lpcr_action_e;

  typedef enum logic [2:0] {
    EvNone    = 3'd0,
    EvSend    = 3'd1,
    EvData    = 3'd2,
    EvDone    = 3'd3,
    EvFail    = 3'd4,
    EvTimeout = 3'd5
  } lpcr_event_e;

  typedef enum logic [1:0] {
    PhDigits  = 2'd0,
    PhSkip    = 2'd1,
    PhPayload = 2'd2
  } lpcr_phase_e;

  typedef struct packed {
    logic [15:0] retry_interval_ms;
    logic [15:0] response_timeout_ms;
    logic [3:0]  retry_limit;
    logic [12:0] max_length;
    logic [31:0] chunk_offset;
    logic        link_ready;
  } lpcr_cfg_t;

  typedef struct packed {
    lpcr_event_e ev;
    logic [31:0] command_offset;
    logic [12:0] command_length;
    logic [11:0] write_address;
    logic [7:0]  write_data;
    logic [12:0] read_length;
  } lpcr_result_t;

endpackage

`default_nettype wire

// ===== rtl/lpcr_cfg_regs.sv =====
// APB configuration register bank of the chunk reader.
`timescale 1ns / 1ps
`default_nettype none

module lpcr_cfg_regs import lpcr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output lpcr_cfg_t        cfg_o
);

  lpcr_cfg_t cfg_q;
  lpcr_reg_e reg_sel;
  logic      wr_en;

  assign reg_sel = lpcr_reg_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.retry_interval_ms   <= ResetRetryInterval;
      cfg_q.response_timeout_ms <= ResetRespTimeout;
      cfg_q.retry_limit         <= ResetRetryLimit;
      cfg_q.max_length          <= ResetMaxLength;
      cfg_q.chunk_offset        <= ResetChunkOffset;
      cfg_q.link_ready          <= ResetLinkReady;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegRetryInterval: cfg_q.retry_interval_ms   <= pwdata[15:0];
        RegRespTimeout:   cfg_q.response_timeout_ms <= pwdata[15:0];
        RegRetryLimit:    cfg_q.retry_limit         <= pwdata[3:0];
        RegMaxLength:     cfg_q.max_length          <= pwdata[12:0];
        RegChunkOffset:   cfg_q.chunk_offset        <= pwdata;
        RegLinkReady:     cfg_q.link_ready          <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegRetryInterval: prdata = {16'd0, cfg_q.retry_interval_ms};
      RegRespTimeout:   prdata = {16'd0, cfg_q.response_timeout_ms};
      RegRetryLimit:    prdata = {28'd0, cfg_q.retry_limit};
      RegMaxLength:     prdata = {19'd0, cfg_q.max_length};
      RegChunkOffset:   prdata = cfg_q.chunk_offset;
      RegLinkReady:     prdata = {31'd0, cfg_q.link_ready};
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/lpcr_engine.sv =====
// Retry/timeout control and report parser: state registers and per-item result logic.
`timescale 1ns / 1ps
`default_nettype none

module lpcr_engine import lpcr_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire lpcr_cfg_t    cfg_i,
  input  wire logic         fire_i,
  input  wire logic [1:0]   action_i,
  input  wire logic [7:0]   byte_i,
  output lpcr_result_t      res_o
);

  logic            waiting_q, waiting_d;
  logic [3:0]      retry_q, retry_d;
  logic [15:0]     elapsed_q, elapsed_d;
  lpcr_phase_e     phase_q, phase_d;
  logic [3:0]      digits_q, digits_d;
  logic [LenW-1:0] declared_q, declared_d;
  logic [12:0]     copied_q, copied_d;

  lpcr_action_e    act;
  logic [15:0]     elapsed_inc;
  logic [12:0]     copied_inc;
  logic [17:0]     acc;
  logic            is_digit;

  assign act         = lpcr_action_e'(action_i);
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign copied_inc  = copied_q + 13'd1;
  assign acc         = {1'b0, declared_q, 3'b000} + {3'b000, declared_q, 1'b0}
                     + {10'd0, byte_i - CharZero};
  assign is_digit    = (byte_i >= CharZero) && (byte_i <= CharNine);

  always_comb begin
    waiting_d  = waiting_q;
    retry_d    = retry_q;
    elapsed_d  = elapsed_q;
    phase_d    = phase_q;
    digits_d   = digits_q;
    declared_d = declared_q;
    copied_d   = copied_q;
    res_o      = '0;
    res_o.ev   = EvNone;

    if (!cfg_i.link_ready) begin
      res_o.ev = EvFail;
    end else begin
      unique case (act)
        ActTick: begin
          elapsed_d = elapsed_inc;
          if (!waiting_q) begin
            if (elapsed_inc > cfg_i.retry_interval_ms) begin
              elapsed_d            = '0;
              waiting_d            = 1'b1;
              res_o.ev             = EvSend;
              res_o.command_offset = cfg_i.chunk_offset;
              res_o.command_length = cfg_i.max_length;
            end
          end else if (elapsed_inc > cfg_i.response_timeout_ms) begin
            phase_d    = PhDigits;
            digits_d   = '0;
            declared_d = '0;
            copied_d   = '0;
            waiting_d  = 1'b0;
            if (retry_q >= cfg_i.retry_limit) begin
              retry_d  = '0;
              res_o.ev = EvTimeout;
            end else begin
              retry_d = retry_q + 4'd1;
            end
          end
        end
        ActError: begin
          if (waiting_q) begin
            waiting_d = 1'b0;
            if (retry_q >= cfg_i.retry_limit) begin
              retry_d  = '0;
              res_o.ev = EvFail;
            end else begin
              retry_d = retry_q + 4'd1;
            end
          end
        end
        ActByte: begin
          if (waiting_q) begin
            unique case (phase_q)
              PhSkip: begin
                copied_d = '0;
                if (declared_q > {1'b0, cfg_i.max_length} || declared_q > LenBuffer) begin
                  res_o.ev = EvFail;
                  waiting_d = 1'b0; retry_d = '0; phase_d = PhDigits;
                  digits_d  = '0;   declared_d = '0;
                end else if (declared_q == '0) begin
                  res_o.ev = EvDone;
                  waiting_d = 1'b0; retry_d = '0; phase_d = PhDigits;
                  digits_d  = '0;   declared_d = '0;
                end else begin
                  phase_d = PhPayload;
                end
              end
              PhPayload: begin
                res_o.write_address = copied_q[11:0];
                res_o.write_data    = byte_i;
                copied_d            = copied_inc;
                if ({1'b0, copied_inc} >= declared_q) begin
                  res_o.ev          = EvDone;
                  res_o.read_length = declared_q[12:0];
                  waiting_d = 1'b0; retry_d = '0; phase_d = PhDigits;
                  digits_d  = '0;   declared_d = '0; copied_d = '0;
                end else begin
                  res_o.ev = EvData;
                end
              end
              default: begin
                phase_d = PhDigits;
                if (byte_i == CharCr) begin
                  digits_d = '0;
                  phase_d  = PhSkip;
                end else if (is_digit && digits_q < DigitsMax) begin
                  declared_d = (acc > {4'd0, LenSat}) ? LenSat : acc[LenW-1:0];
                  digits_d   = digits_q + 4'd1;
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q  <= 1'b0;
      retry_q    <= '0;
      elapsed_q  <= 16'hFFFF;
      phase_q    <= PhDigits;
      digits_q   <= '0;
      declared_q <= '0;
      copied_q   <= '0;
    end else if (fire_i) begin
      waiting_q  <= waiting_d;
      retry_q    <= retry_d;
      elapsed_q  <= elapsed_d;
      phase_q    <= phase_d;
      digits_q   <= digits_d;
      declared_q <= declared_d;
      copied_q   <= copied_d;
    end
  end

  a_copy_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> copied_q < declared_q[12:0] || declared_q > 14'd4096)
    else $error("payload count reached declared length without finishing");

  a_len_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    declared_q <= LenSat)
    else $error("length accumulator beyond saturation value");

  a_digits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_q <= DigitsMax)
    else $error("digit count beyond limit");

  a_send_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.ev == EvSend |=> waiting_q && elapsed_q == '0)
    else $error("command sent without entering wait");

endmodule

`default_nettype wire

// ===== rtl/length_prefixed_chunk_reader.sv =====
// Top level of the length-prefixed chunk reader: input register, engine, result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | input     | in_valid_i / in_stall_o | action_i, report_byte_i
//  out     | output    | out_valid_o/out_stall_i | event_res_o, command_*_o, write_*_o,
//          |           |                         | read_length_o
//  cfg     | input     | APB psel/penable/pready | paddr, pwdata, prdata
//
// One item per cycle sustained while the output is not stalled; the input register loads at the
// accepting edge and the result register loads from the parser/retry logic when the item is
// processed, and drives the outputs.
// Reset loads register defaults, clears the parser and sets the ms counter to all ones.
// A stalled result holds; the input register still takes one item, then in_stall_o rises.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_chunk_reader import lpcr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [7:0]  report_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       event_res_o,
  output logic [31:0]      command_offset_o,
  output logic [12:0]      command_length_o,
  output logic [11:0]      write_address_o,
  output logic [7:0]       write_data_o,
  output logic [12:0]      read_length_o
);

  lpcr_cfg_t    cfg;
  lpcr_result_t res_d, res_q;
  logic         in_valid_q, out_valid_q;
  logic [1:0]   action_q;
  logic [7:0]   byte_q;
  logic         out_free, fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  lpcr_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lpcr_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .fire_i   (fire),
    .action_i (action_q),
    .byte_i   (byte_q),
    .res_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      action_q <= action_i;
      byte_q   <= report_byte_i;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_res_o      = res_q.ev;
  assign command_offset_o = res_q.command_offset;
  assign command_length_o = res_q.command_length;
  assign write_address_o  = res_q.write_address;
  assign write_data_o     = res_q.write_data;
  assign read_length_o    = res_q.read_length;

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with room downstream");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed item produced no result");

endmodule

`default_nettype wire
